// ===== hw/rtl/wcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Wave channel sample generator package
// Shared types and register indexes for the wave-table audio channel.
// ----------------------------------------------------------------------------
package wcsg_pkg;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SEQ  = 2'd1,
    REQ_TRIG = 2'd2
  } req_type_e;

  // volume codes
  typedef enum logic [1:0] {
    VOL_MUTE    = 2'd0,
    VOL_FULL    = 2'd1,
    VOL_HALF    = 2'd2,
    VOL_QUARTER = 2'd3
  } vol_code_e;

  // configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PERIOD     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_VOLUME     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEN_LOAD   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEN_ENABLE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WAVE_LOW   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WAVE_HIGH  = 3'd5;

  // field widths
  localparam int unsigned PeriodW = 11;
  localparam int unsigned PosW    = 5;
  localparam int unsigned LenW    = 9;
  localparam int unsigned SampleW = 4;

  // full length counter value loaded on trigger before subtracting the load
  localparam logic [LenW-1:0] LEN_FULL = 9'd256;

  // one result beat
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               channel_on;
  } result_t;

  // configuration write bundle
  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/wcsg_if.sv =====
// ----------------------------------------------------------------------------
// Wave channel stream interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface wcsg_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] seq_phase;

  modport source (output valid, output req_type, output seq_phase, input ready);
  modport sink   (input valid, input req_type, input seq_phase, output ready);
endinterface

interface wcsg_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] sample;
  logic       channel_on;

  modport source (output valid, output sample, output channel_on, input ready);
  modport sink   (input valid, input sample, input channel_on, output ready);
endinterface

// ===== hw/rtl/wcsg_core.sv =====
// ----------------------------------------------------------------------------
// Wave channel core
// Configuration registers and channel state; updates the state once per
// accepted request beat and presents the resulting sample and enable.
// ----------------------------------------------------------------------------
module wcsg_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wcsg_pkg::cfg_wr_t  cfg_i,
  input  logic               fire_i,
  input  logic [1:0]         req_type_i,
  input  logic [2:0]         seq_phase_i,
  output wcsg_pkg::result_t  res_o
);

  // configuration registers
  logic [wcsg_pkg::PeriodW-1:0] period_value_q;
  logic [1:0]                   volume_code_q;
  logic [7:0]                   length_load_q;
  logic                         length_enable_q;
  logic [63:0]                  wave_low_q;
  logic [63:0]                  wave_high_q;

  // channel state
  logic [wcsg_pkg::PeriodW-1:0] period_q, period_d;
  logic [wcsg_pkg::PosW-1:0]    pos_q, pos_d;
  logic [wcsg_pkg::LenW-1:0]    len_q, len_d;
  logic                         active_q, active_d;
  logic [wcsg_pkg::SampleW-1:0] sample_q, sample_d;

  logic [wcsg_pkg::PosW-1:0]    pos_next;
  logic [63:0]                  wave_word;
  logic [3:0]                   nib_idx;
  logic [3:0]                   nibble;
  logic [3:0]                   scaled;

  // take configuration writes; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_value_q  <= '0;
      volume_code_q   <= '0;
      length_load_q   <= '0;
      length_enable_q <= 1'b0;
      wave_low_q      <= '0;
      wave_high_q     <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        wcsg_pkg::CFG_PERIOD:     period_value_q  <= cfg_i.data[wcsg_pkg::PeriodW-1:0];
        wcsg_pkg::CFG_VOLUME:     volume_code_q   <= cfg_i.data[1:0];
        wcsg_pkg::CFG_LEN_LOAD:   length_load_q   <= cfg_i.data[7:0];
        wcsg_pkg::CFG_LEN_ENABLE: length_enable_q <= cfg_i.data[0];
        wcsg_pkg::CFG_WAVE_LOW:   wave_low_q      <= cfg_i.data;
        wcsg_pkg::CFG_WAVE_HIGH:  wave_high_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // fetch the nibble at the advanced position, high nibble first
  assign pos_next  = pos_q + wcsg_pkg::PosW'(1);
  assign wave_word = pos_next[4] ? wave_high_q : wave_low_q;
  assign nib_idx   = 4'hF - pos_next[3:0];
  assign nibble    = wave_word[{nib_idx, 2'b00} +: 4];

  // apply the volume code
  always_comb begin
    unique case (wcsg_pkg::vol_code_e'(volume_code_q))
      wcsg_pkg::VOL_MUTE:    scaled = 4'd0;
      wcsg_pkg::VOL_FULL:    scaled = nibble;
      wcsg_pkg::VOL_HALF:    scaled = nibble >> 1;
      wcsg_pkg::VOL_QUARTER: scaled = nibble >> 2;
      default:               scaled = 4'd0;
    endcase
  end

  // next channel state for the current request
  always_comb begin
    period_d = period_q;
    pos_d    = pos_q;
    len_d    = len_q;
    active_d = active_q;
    sample_d = sample_q;
    unique case (req_type_i)
      wcsg_pkg::REQ_TICK: begin
        if (active_q) begin
          if (period_q == {wcsg_pkg::PeriodW{1'b1}}) begin
            period_d = period_value_q;
            pos_d    = pos_next;
            sample_d = scaled;
          end else begin
            period_d = period_q + wcsg_pkg::PeriodW'(1);
          end
        end
      end
      wcsg_pkg::REQ_SEQ: begin
        if (!seq_phase_i[0] && length_enable_q && (len_q != '0)) begin
          len_d = len_q - wcsg_pkg::LenW'(1);
          if (len_q == wcsg_pkg::LenW'(1)) begin
            active_d = 1'b0;
          end
        end
      end
      wcsg_pkg::REQ_TRIG: begin
        len_d    = wcsg_pkg::LEN_FULL - {1'b0, length_load_q};
        pos_d    = '0;
        period_d = period_value_q;
        active_d = 1'b1;
      end
      default: ;
    endcase
  end

  // commit state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      pos_q    <= '0;
      len_q    <= '0;
      active_q <= 1'b0;
      sample_q <= '0;
    end else if (fire_i) begin
      period_q <= period_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      active_q <= active_d;
      sample_q <= sample_d;
    end
  end

  // result reflects the state after this beat
  assign res_o.sample     = sample_d;
  assign res_o.channel_on = active_d;

`ifndef SYNTHESIS
  a_trig_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_type_i == wcsg_pkg::REQ_TRIG) |=> active_q && (pos_q == '0))
    else $error("trigger did not enable channel");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= wcsg_pkg::LEN_FULL)
    else $error("length counter above full value");

  a_idle_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_type_i == wcsg_pkg::REQ_TICK) && !active_q
      |=> $stable(period_q) && $stable(pos_q) && $stable(sample_q))
    else $error("disabled channel changed state on tick");
`endif

endmodule

// ===== hw/rtl/wcsg_out_buf.sv =====
// ----------------------------------------------------------------------------
// Wave channel result buffer
// Two-entry result queue that decouples the request side from output stalls.
// ----------------------------------------------------------------------------
module wcsg_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wcsg_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output wcsg_pkg::result_t data_o
);

  wcsg_pkg::result_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              pop;

  assign pop     = valid_o && pop_ready_i;
  assign valid_o = (count_q != 2'd0);
  assign ready_o = (count_q != 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  // store each pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // advance pointers and track fill; hold the count on push with pop or on idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != 2'd2)
    else $error("push into full result buffer");

  a_fill_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("result buffer pointers out of step");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i && !pop |=> $stable(count_q))
    else $error("result buffer fill changed without a beat");
`endif

endmodule

// ===== hw/rtl/wave_channel_sample_generator.sv =====
// ----------------------------------------------------------------------------
// Wave channel sample generator
// Each result beat is written into the result queue as its request beat is taken.
// Throughput: one request beat per cycle while the result queue has room.
// A two-entry result queue keeps requests flowing while one result waits.
// Reset: asynchronous, clears configuration, channel state and the queue.
// ----------------------------------------------------------------------------
module wave_channel_sample_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wcsg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wcsg_pkg::CfgDataW-1:0]    cfg_data_i,
  wcsg_req_if.sink                         req,
  wcsg_res_if.source                       res
);

  wcsg_pkg::cfg_wr_t cfg;
  wcsg_pkg::result_t core_res;
  wcsg_pkg::result_t buf_res;
  logic              fire;
  logic              buf_ready;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // accept a request beat whenever the queue has room
  assign req.ready = buf_ready;
  assign fire      = req.valid && buf_ready;

  wcsg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .req_type_i  (req.req_type),
    .seq_phase_i (req.seq_phase),
    .res_o       (core_res)
  );

  wcsg_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .data_i      (core_res),
    .ready_o     (buf_ready),
    .valid_o     (res.valid),
    .pop_ready_i (res.ready),
    .data_o      (buf_res)
  );

  assign res.sample     = buf_res.sample;
  assign res.channel_on = buf_res.channel_on;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wave channel sample generator testbench
// Drives tick, sequencer and trigger beats through the request channel and
// checks every result beat against a cycle-free model of the channel kept
// here, across several register settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import wcsg_pkg::*;

  localparam int RunLimit    = 200000;
  localparam int SegItems    = 280;
  localparam int StallAt     = 1500;
  localparam int StallCycles = 200;

  // indexes past the last register; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    req_type_e  kind;
    logic [2:0] phase;
  } wave_req_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  wcsg_req_if req_ch ();
  wcsg_res_if res_ch ();

  wave_channel_sample_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .res        (res_ch)
  );

  // model registers
  logic [10:0] reg_period  = '0;
  vol_code_e   reg_volume  = VOL_MUTE;
  logic [7:0]  reg_len_load = '0;
  logic        reg_len_en  = 1'b0;
  logic [63:0] reg_wave_lo = '0;
  logic [63:0] reg_wave_hi = '0;

  // model channel state
  logic [10:0] period_cnt = '0;
  logic [4:0]  nib_pos    = '0;
  logic [8:0]  len_cnt    = '0;
  logic        ch_on      = 1'b0;
  logic [3:0]  cur_sample = '0;

  wave_req_t pending_reqs[$];
  result_t   due_samples[$];

  int src_idle_pct;
  int snk_idle_pct;
  int n_taken;
  int stall_left;
  bit stall_done;
  int mismatches;
  int cycle_cnt;
  int n_ticks, n_seqs, n_trigs, n_advances, n_expiries, n_settings;

  always #5 clk_i = ~clk_i;

  // nibble at a wave position, scaled by the volume code
  function automatic logic [3:0] scaled_nibble(input logic [4:0] pos);
    logic [63:0] word;
    logic [3:0]  nib;
    word = pos[4] ? reg_wave_hi : reg_wave_lo;
    nib  = 4'(word >> (4 * (15 - pos[3:0])));
    case (reg_volume)
      VOL_MUTE: return 4'd0;
      VOL_FULL: return nib;
      VOL_HALF: return nib >> 1;
      default:  return nib >> 2;
    endcase
  endfunction

  // advance the channel by one request and queue the sample it leaves
  task automatic step_wave_channel(input wave_req_t r);
    case (r.kind)
      REQ_TICK: begin
        n_ticks++;
        if (ch_on) begin
          if (period_cnt == 11'h7FF) begin
            period_cnt = reg_period;
            nib_pos    = nib_pos + 5'd1;
            cur_sample = scaled_nibble(nib_pos);
            n_advances++;
          end else begin
            period_cnt = period_cnt + 11'd1;
          end
        end
      end
      REQ_SEQ: begin
        n_seqs++;
        if (!r.phase[0] && reg_len_en && len_cnt != '0) begin
          len_cnt = len_cnt - 9'd1;
          if (len_cnt == '0) begin
            ch_on = 1'b0;
            n_expiries++;
          end
        end
      end
      REQ_TRIG: begin
        n_trigs++;
        len_cnt    = LEN_FULL - {1'b0, reg_len_load};
        nib_pos    = '0;
        period_cnt = reg_period;
        ch_on      = 1'b1;
      end
      default: ;
    endcase
    due_samples.push_back('{sample: cur_sample, channel_on: ch_on});
  endtask

  // compare one result beat with the oldest expected sample
  task automatic check_result(input logic [3:0] smp, input logic on);
    result_t want;
    if (due_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: sample %0d channel_on %0d", smp, on);
    end else begin
      want = due_samples.pop_front();
      if (smp !== want.sample || on !== want.channel_on) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: sample exp %0d got %0d, channel_on exp %0d got %0d",
                   want.sample, smp, want.channel_on, on);
      end
    end
  endtask

  // one register write; the model takes it at once since the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_PERIOD:     reg_period   = data[10:0];
      CFG_VOLUME:     reg_volume   = vol_code_e'(data[1:0]);
      CFG_LEN_LOAD:   reg_len_load = data[7:0];
      CFG_LEN_ENABLE: reg_len_en   = data[0];
      CFG_WAVE_LOW:   reg_wave_lo  = data;
      CFG_WAVE_HIGH:  reg_wave_hi  = data;
      default: ;
    endcase
  endtask

  task automatic configure_channel(input logic [10:0] period, input vol_code_e vol,
                                   input logic [7:0] len_load, input logic len_en,
                                   input logic [63:0] wave_lo, input logic [63:0] wave_hi);
    write_reg(CFG_PERIOD, 64'(period));
    write_reg(CFG_VOLUME, 64'(vol));
    write_reg(CFG_LEN_LOAD, 64'(len_load));
    write_reg(CFG_LEN_ENABLE, 64'(len_en));
    write_reg(CFG_WAVE_LOW, wave_lo);
    write_reg(CFG_WAVE_HIGH, wave_hi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic push_req(input req_type_e kind, input logic [2:0] phase);
    pending_reqs.push_back('{kind: kind, phase: phase});
  endtask

  // mostly ticks, with sequencer steps and the odd trigger mixed in
  task automatic queue_random_reqs(input int n);
    wave_req_t   r;
    int unsigned roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 6)       r.kind = REQ_TRIG;
      else if (roll < 26) r.kind = REQ_SEQ;
      else                r.kind = REQ_TICK;
      r.phase = 3'($urandom_range(7));
      pending_reqs.push_back(r);
    end
  endtask

  // wait until every request is taken and every result checked
  task automatic drain;
    while (pending_reqs.size() != 0 || due_samples.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // request driver: hold a beat until taken, otherwise offer the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        step_wave_channel(pending_reqs.pop_front());
        n_taken <= n_taken + 1;
      end
      if (req_ch.valid && !req_ch.ready) begin
        req_ch.valid <= 1'b1;
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= pending_reqs[0].kind;
        req_ch.seq_phase <= pending_reqs[0].phase;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor: check taken beats, stall at random or during the hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_result(res_ch.sample, res_ch.channel_on);
      res_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // one long receiver hold-off so the result queue fills and input stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && n_taken >= StallAt) begin
      stall_left <= StallCycles;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // run watchdog
  initial begin
    for (cycle_cnt = 0; cycle_cnt < RunLimit; cycle_cnt++) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_PERIOD;
    cfg_data_i       = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_TICK;
    req_ch.seq_phase = '0;
    res_ch.ready     = 1'b0;
    src_idle_pct     = 31;
    snk_idle_pct     = 48;
    n_taken          = 0;
    mismatches       = 0;
    n_ticks = 0; n_seqs = 0; n_trigs = 0;
    n_advances = 0; n_expiries = 0; n_settings = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: disabled channel, odd and even phases, length expiry, retrigger
    configure_channel(11'd2047, VOL_FULL, 8'd254, 1'b1,
                      64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    push_req(REQ_TICK, 3'd0);
    push_req(REQ_SEQ, 3'd0);
    push_req(REQ_TRIG, 3'd0);
    repeat (4) push_req(REQ_TICK, 3'd7);
    push_req(REQ_SEQ, 3'd1);
    push_req(REQ_SEQ, 3'd3);
    push_req(REQ_SEQ, 3'd7);
    push_req(REQ_SEQ, 3'd0);
    push_req(REQ_SEQ, 3'd2);
    push_req(REQ_TICK, 3'd0);
    push_req(REQ_TRIG, 3'd0);
    push_req(REQ_SEQ, 3'd4);
    push_req(REQ_SEQ, 3'd6);
    push_req(REQ_TRIG, 3'd0);
    repeat (3) push_req(REQ_TICK, 3'd0);
    push_req(REQ_SEQ, 3'd5);
    push_req(REQ_TRIG, 3'd0);
    drain();

    // random segments, each under its own setting; idle patterns change every two segments
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0, 1: begin src_idle_pct = 31; snk_idle_pct = 48; end
        2, 3: begin src_idle_pct = 48; snk_idle_pct = 31; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      case (seg)
        0: configure_channel(11'd2047, VOL_FULL, 8'd255, 1'b1,
                             {$urandom, $urandom}, {$urandom, $urandom});
        1: configure_channel(11'd2045, VOL_HALF, 8'($urandom_range(255, 240)), 1'b1,
                             {$urandom, $urandom}, {$urandom, $urandom});
        2: configure_channel(11'd2038, VOL_QUARTER, 8'd250, 1'b0,
                             {$urandom, $urandom}, {$urandom, $urandom});
        3: configure_channel(11'd0, VOL_MUTE, 8'd0, 1'b1, '1, '1);
        4: configure_channel(11'($urandom_range(2047, 2030)),
                             vol_code_e'($urandom_range(3)),
                             8'($urandom_range(255)), 1'($urandom_range(1)),
                             {$urandom, $urandom}, {$urandom, $urandom});
        default: begin
          configure_channel(11'd2046, VOL_FULL, 8'd252, 1'b1,
                            {$urandom, $urandom}, {$urandom, $urandom});
          // spare indexes must not disturb any register
          write_reg(CFG_SPARE_A, {$urandom, $urandom});
          write_reg(CFG_SPARE_B, {$urandom, $urandom});
          @(posedge clk_i);
          cfg_we_i <= 1'b0;
        end
      endcase
      queue_random_reqs(SegItems);
      drain();
    end

    $display("covered %0d request beats (%0d ticks, %0d sequencer steps, %0d triggers)",
             n_ticks + n_seqs + n_trigs, n_ticks, n_seqs, n_trigs);
    $display("%0d wave steps played, %0d length expiries, %0d register settings",
             n_advances, n_expiries, n_settings);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
